### hdl/stepper_ramp_step_generator_core_defines.svh
// Assertion macros for the stepper ramp step generator core.
// Included by the top level; no other dependencies.
`ifndef STEPPER_RAMP_STEP_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_STEP_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SRSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SRSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/srsg_pkg.sv
// Shared types and constants for the stepper ramp step generator.
// No dependencies.
package srsg_pkg;

    localparam int MODE_W     = 2;
    localparam int VALUE_W    = 13;
    localparam int SPEED_W    = 12;
    localparam int RPM_STEP_W = 12;
    localparam int RAMP_W     = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SPEED_MAX         = 2**SPEED_W - 1;
    localparam int MICROS_PER_MINUTE = 60000000;

    localparam int DEF_MAX_RPM          = 4095;
    localparam int DEF_STEPS_PER_REV    = 1600;
    localparam int DEF_MICROS_PER_MILLI = 1000;

    localparam logic [RPM_STEP_W-1:0] RPM_STEP_RESET  = RPM_STEP_W'(10);
    localparam logic [RAMP_W-1:0]     RAMP_INTV_RESET = RAMP_W'(10);

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TARGET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ENABLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RPM_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTV = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_PREP,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic ramp;
        logic div_start;
        logic div_step;
        logic step_check;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic tick;
        logic run_step;
        logic div_last;
    } sts_t;

endpackage

### hdl/srsg_ctrl.sv
// Sequencer for the step generator: item acceptance, speed ramp, divide pass, step check, result transfer.
// Depends on srsg_pkg.
module srsg_ctrl
    import srsg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (sts.tick && sts.run_step)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_RAMP:
            begin
                cmd.ramp = 1'b1;
            end
            ST_PREP:
            begin
                cmd.div_start = sts.tick && sts.run_step;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.step_check = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/srsg_datapath.sv
// Time counters, speed ramp, restoring step-interval divider and result register.
// Depends on srsg_pkg.
module srsg_datapath
    import srsg_pkg::*;
#(
    parameter int MAX_RPM          = DEF_MAX_RPM,
    parameter int STEPS_PER_REV    = DEF_STEPS_PER_REV,
    parameter int MICROS_PER_MILLI = DEF_MICROS_PER_MILLI
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic [MODE_W-1:0]         mode,
    input  logic signed [VALUE_W-1:0] value,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    output logic                      step_pulse,
    output logic [SPEED_W-1:0]        current_speed,
    output logic                      direction,
    output logic                      driver_enabled
);

    localparam int SPD_LIM  = (MAX_RPM > SPEED_MAX) ? SPEED_MAX : MAX_RPM;
    localparam int STEP_NUM = MICROS_PER_MINUTE / STEPS_PER_REV;
    localparam int NUM_W    = $clog2(STEP_NUM + 1);
    localparam int CNT_W    = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam int MIM_W    = $clog2(MICROS_PER_MILLI + 1);

    localparam logic [SPEED_W-1:0] LIM_V      = SPEED_W'(SPD_LIM);
    localparam logic [NUM_W-1:0]   STEP_NUM_V = NUM_W'(STEP_NUM);
    localparam logic [MIM_W-1:0]   MPM_V      = MIM_W'(MICROS_PER_MILLI);
    localparam logic [CNT_W-1:0]   CNT_LAST_V = CNT_W'(NUM_W - 1);

    logic [RPM_STEP_W-1:0] rpm_step_reg;
    logic [RAMP_W-1:0]     ramp_intv_reg;
    logic [TIME_W-1:0]     micro_reg,     micro_next;
    logic [MIM_W-1:0]      mim_reg,       mim_next;
    logic [TIME_W-1:0]     milli_reg,     milli_next;
    logic [TIME_W-1:0]     last_ramp_reg, last_ramp_next;
    logic [TIME_W-1:0]     last_step_reg, last_step_next;
    logic [SPEED_W-1:0]    target_reg,    target_next;
    logic [SPEED_W-1:0]    speed_reg,     speed_next;
    logic                  enabled_reg,   enabled_next;
    logic                  dir_reg,       dir_next;
    logic                  tick_reg,      tick_next;
    logic                  pulse_reg,     pulse_next;
    logic [NUM_W-1:0]      num_reg,       num_next;
    logic [SPEED_W-1:0]    rem_reg,       rem_next;
    logic [CNT_W-1:0]      cnt_reg,       cnt_next;

    logic [MIM_W-1:0]   mim_inc;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [SPEED_W:0]   ramp_up;
    logic [SPEED_W-1:0] ramp_dn;
    logic [SPEED_W-1:0] ramp_val;
    logic [TIME_W-1:0]  ramp_elapsed;
    logic [TIME_W-1:0]  step_elapsed;
    logic [SPEED_W:0]   trial;
    logic               trial_ok;

    assign mim_inc      = mim_reg + MIM_W'(1);
    assign neg          = value[VALUE_W-1];
    assign mag          = neg ? (~value + VALUE_W'(1)) : value;
    assign ramp_elapsed = milli_reg - last_ramp_reg;
    assign step_elapsed = micro_reg - last_step_reg;
    assign trial        = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ok     = trial >= {1'b0, speed_reg};

    always_comb
    begin
        ramp_up = {1'b0, speed_reg} + {{(SPEED_W + 1 - RPM_STEP_W){1'b0}}, rpm_step_reg};
        ramp_dn = (speed_reg > rpm_step_reg) ? (speed_reg - rpm_step_reg) : '0;
        if (speed_reg < target_reg)
        begin
            ramp_val = (ramp_up > {1'b0, target_reg}) ? target_reg : ramp_up[SPEED_W-1:0];
        end
        else if (speed_reg > target_reg)
        begin
            ramp_val = (ramp_dn < target_reg) ? target_reg : ramp_dn;
        end
        else
        begin
            ramp_val = speed_reg;
        end
    end

    always_comb
    begin
        micro_next     = micro_reg;
        mim_next       = mim_reg;
        milli_next     = milli_reg;
        last_ramp_next = last_ramp_reg;
        last_step_next = last_step_reg;
        target_next    = target_reg;
        speed_next     = speed_reg;
        enabled_next   = enabled_reg;
        dir_next       = dir_reg;
        tick_next      = tick_reg;
        pulse_next     = pulse_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;

        if (cmd.accept)
        begin
            tick_next  = (mode == MODE_TICK);
            pulse_next = 1'b0;
            case (mode)
                MODE_TICK:
                begin
                    micro_next = micro_reg + TIME_W'(1);
                    if (mim_inc >= MPM_V)
                    begin
                        mim_next   = '0;
                        milli_next = milli_reg + TIME_W'(1);
                    end
                    else
                    begin
                        mim_next = mim_inc;
                    end
                end
                MODE_TARGET:
                begin
                    target_next = (mag > {1'b0, LIM_V}) ? LIM_V : mag[SPEED_W-1:0];
                    dir_next    = !neg;
                end
                MODE_ENABLE:
                begin
                    enabled_next = (value != '0);
                    if (value == '0)
                    begin
                        target_next = '0;
                        speed_next  = '0;
                    end
                end
                default:
                begin
                    tick_next = 1'b0;
                end
            endcase
        end

        if (cmd.ramp && tick_reg && (ramp_elapsed >= {{(TIME_W - RAMP_W){1'b0}}, ramp_intv_reg}))
        begin
            last_ramp_next = milli_reg;
            speed_next     = ramp_val;
        end

        if (cmd.div_start)
        begin
            num_next = STEP_NUM_V;
            rem_next = '0;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            // shift in one numerator bit, subtract when it fits, quotient fills from the right
            rem_next = trial_ok ? SPEED_W'(trial - {1'b0, speed_reg}) : trial[SPEED_W-1:0];
            num_next = {num_reg[NUM_W-2:0], trial_ok};
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.step_check && (step_elapsed >= {{(TIME_W - NUM_W){1'b0}}, num_reg}))
        begin
            pulse_next     = 1'b1;
            last_step_next = micro_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_step_reg  <= RPM_STEP_RESET;
            ramp_intv_reg <= RAMP_INTV_RESET;
            micro_reg     <= '0;
            mim_reg       <= '0;
            milli_reg     <= '0;
            last_ramp_reg <= '0;
            last_step_reg <= '0;
            target_reg    <= '0;
            speed_reg     <= '0;
            enabled_reg   <= 1'b0;
            dir_reg       <= 1'b1;
            tick_reg      <= 1'b0;
            pulse_reg     <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_RPM_STEP:
                    begin
                        rpm_step_reg <= cfg_data[RPM_STEP_W-1:0];
                    end
                    REG_RAMP_INTV:
                    begin
                        ramp_intv_reg <= cfg_data[RAMP_W-1:0];
                    end
                    default:
                    begin
                        rpm_step_reg <= rpm_step_reg;
                    end
                endcase
            end
            micro_reg     <= micro_next;
            mim_reg       <= mim_next;
            milli_reg     <= milli_next;
            last_ramp_reg <= last_ramp_next;
            last_step_reg <= last_step_next;
            target_reg    <= target_next;
            speed_reg     <= speed_next;
            enabled_reg   <= enabled_next;
            dir_reg       <= dir_next;
            tick_reg      <= tick_next;
            pulse_reg     <= pulse_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (cmd.out_load)
        begin
            step_pulse     <= pulse_reg;
            current_speed  <= speed_reg;
            direction      <= dir_reg;
            driver_enabled <= enabled_reg;
        end
    end

    assign sts.tick     = tick_reg;
    assign sts.run_step = enabled_reg && (speed_reg != '0);
    assign sts.div_last = (cnt_reg == CNT_LAST_V);

endmodule

### hdl/stepper_ramp_step_generator_core.sv
// Top level of the stepper ramp step generator: controller plus datapath.
// Depends on srsg_pkg, srsg_ctrl, srsg_datapath and the core defines header.
//
//   channel | signals                                           | dir
//   --------+---------------------------------------------------+-----
//   input   | in_valid, in_ready, mode, value                   | in
//   result  | out_valid, out_ready, step_pulse, current_speed,  | out
//           | direction, driver_enabled                         |
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data         | in
//
// A tick with stepping active goes through the ramp, prepare, divide and check states
// before its result loads in the finish state; the restoring divider yields one quotient
// bit per cycle over NUM_W, the bit count of 60000000 / STEPS_PER_REV (16 by default). Other
// items go from prepare straight to finish; the next input is taken in the cycle after the load.
// Reset gives target and speed 0, forward, disabled. A stalled result holds the core
// in its final state until the result register accepts the new result.
`include "stepper_ramp_step_generator_core_defines.svh"

module stepper_ramp_step_generator_core
    import srsg_pkg::*;
#(
    parameter int MAX_RPM          = DEF_MAX_RPM,
    parameter int STEPS_PER_REV    = DEF_STEPS_PER_REV,
    parameter int MICROS_PER_MILLI = DEF_MICROS_PER_MILLI
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [MODE_W-1:0]         mode,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      step_pulse,
    output logic [SPEED_W-1:0]        current_speed,
    output logic                      direction,
    output logic                      driver_enabled,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    srsg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srsg_datapath
    #(
        .MAX_RPM          (MAX_RPM),
        .STEPS_PER_REV    (STEPS_PER_REV),
        .MICROS_PER_MILLI (MICROS_PER_MILLI)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .value          (value),
        .cmd            (cmd),
        .sts            (sts),
        .step_pulse     (step_pulse),
        .current_speed  (current_speed),
        .direction      (direction),
        .driver_enabled (driver_enabled)
    );

    `SRSG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input taken again right after a transfer")
    `SRSG_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !out_valid || out_ready,
        "result loaded over a pending result")
    `SRSG_ASSERT_NEXT(a_div_then_check, cmd.div_step && sts.div_last, cmd.step_check,
        "step check missing after last divide step")
    `SRSG_ASSERT_NOW(a_div_only_when_stepping, cmd.div_start, sts.tick && sts.run_step,
        "divide started without an active tick")

endmodule

### verif/tb_top.sv
// Self-checking testbench for stepper_ramp_step_generator_core: ticks, target and enable
// commands against a cycle-free speed ramp and step pulse predictor.
// Depends on srsg_pkg and the core RTL; random pacing on the input and result channels.
module tb_top;
    import srsg_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [VALUE_W-1:0]   ENABLE_OFF  = 13'd0;
    localparam logic [VALUE_W-1:0]   ENABLE_ON   = 13'd1;

    typedef struct packed {
        logic               step_pulse;
        logic [SPEED_W-1:0] current_speed;
        logic               direction;
        logic               driver_enabled;
    } motor_out_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode      = MODE_TICK;
    logic [VALUE_W-1:0]    value     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  step_pulse;
    logic [SPEED_W-1:0]    current_speed;
    logic                  direction;
    logic                  driver_enabled;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [RPM_STEP_W-1:0] cfg_rpm_step = RPM_STEP_RESET;
    logic [RAMP_W-1:0]     cfg_ramp_ms  = RAMP_INTV_RESET;
    logic [TIME_W-1:0]     us_count     = '0;
    logic [9:0]            us_in_ms     = '0;
    logic [TIME_W-1:0]     ms_count     = '0;
    logic [TIME_W-1:0]     last_ramp_ms = '0;
    logic [TIME_W-1:0]     last_step_us = '0;
    logic [SPEED_W-1:0]    target_rpm   = '0;
    logic [SPEED_W-1:0]    ramp_rpm     = '0;
    logic                  en_flag      = 1'b0;
    logic                  dir_flag     = 1'b1;

    motor_out_t  pending_motor_outs[$];
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    int unsigned hold_off_requests = 0;

    stepper_ramp_step_generator_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .step_pulse     (step_pulse),
        .current_speed  (current_speed),
        .direction      (direction),
        .driver_enabled (driver_enabled),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic motor_out_t predict_motor(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] raw);
        motor_out_t        r;
        logic              neg;
        logic [VALUE_W-1:0] mag;
        int unsigned       lim;
        int unsigned       s;
        int unsigned       t;
        longint unsigned   denom;
        longint unsigned   span;
        logic [TIME_W-1:0] elapsed;
        logic              pulse;
        neg   = raw[VALUE_W-1];
        mag   = neg ? VALUE_W'(0 - raw) : raw;
        pulse = 1'b0;
        case (m)
            MODE_TICK:
            begin
                us_count = us_count + 1;
                us_in_ms = us_in_ms + 1;
                if (us_in_ms >= DEF_MICROS_PER_MILLI)
                begin
                    us_in_ms = '0;
                    ms_count = ms_count + 1;
                end
                elapsed = ms_count - last_ramp_ms;
                if (elapsed >= TIME_W'(cfg_ramp_ms))
                begin
                    last_ramp_ms = ms_count;
                    s = ramp_rpm;
                    t = target_rpm;
                    if (s < t)
                    begin
                        s = s + cfg_rpm_step;
                        if (s > t) s = t;
                    end
                    else if (s > t)
                    begin
                        s = (s > cfg_rpm_step) ? s - cfg_rpm_step : 0;
                        if (s < t) s = t;
                    end
                    ramp_rpm = SPEED_W'(s);
                end
                if (en_flag && ramp_rpm != 0)
                begin
                    denom   = longint'(ramp_rpm) * DEF_STEPS_PER_REV;
                    span    = (denom == 0) ? 0 : MICROS_PER_MINUTE / denom;
                    elapsed = us_count - last_step_us;
                    if (longint'(elapsed) >= span)
                    begin
                        last_step_us = us_count;
                        pulse = 1'b1;
                    end
                end
            end
            MODE_TARGET:
            begin
                lim = (DEF_MAX_RPM > SPEED_MAX) ? SPEED_MAX : DEF_MAX_RPM;
                target_rpm = (mag > lim) ? SPEED_W'(lim) : SPEED_W'(mag);
                dir_flag = !neg;
            end
            MODE_ENABLE:
            begin
                en_flag = (raw != 0);
                if (!en_flag)
                begin
                    target_rpm = '0;
                    ramp_rpm   = '0;
                end
            end
            default: ;
        endcase
        r.step_pulse     = pulse;
        r.current_speed  = ramp_rpm;
        r.direction      = dir_flag;
        r.driver_enabled = en_flag;
        return r;
    endfunction

    task automatic send_item(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        pending_motor_outs.push_back(predict_motor(m, v));
    endtask

    task automatic send_random_item(int unsigned tick_pct);
        int unsigned        pick;
        logic [VALUE_W-1:0] v;
        pick = $urandom_range(0, 99);
        v    = VALUE_W'($urandom);
        if (pick < tick_pct)
            send_item(MODE_TICK, v);
        else if (pick < tick_pct + (100 - tick_pct) / 2)
            send_item(MODE_TARGET, v);
        else if (pick < 98)
            send_item(MODE_ENABLE, ($urandom_range(0, 5) == 0) ? ENABLE_OFF :
                                   (($urandom_range(0, 3) == 0) ? v : ENABLE_ON));
        else
            send_item(MODE_UNUSED, v);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_motor_outs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RPM_STEP:  cfg_rpm_step = data[RPM_STEP_W-1:0];
            REG_RAMP_INTV: cfg_ramp_ms  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure(logic [CFG_DATA_W-1:0] rpm_data, logic [CFG_DATA_W-1:0] ramp_data);
        wait_idle();
        write_reg(REG_RPM_STEP, rpm_data);
        write_reg(REG_RAMP_INTV, ramp_data);
    endtask

    task automatic test_command_decode();
        send_item(MODE_TICK, 13'h1FFF);
        send_item(MODE_TICK, 13'h0000);
        send_item(MODE_TARGET, 13'd4095);
        send_item(MODE_TARGET, 13'h1001);
        send_item(MODE_TARGET, 13'h1000);
        send_item(MODE_TARGET, 13'd0);
        send_item(MODE_UNUSED, 13'h1555);
        send_item(MODE_ENABLE, 13'h0AAA);
        send_item(MODE_TARGET, 13'h1FFF);
        send_item(MODE_ENABLE, ENABLE_OFF);
        send_item(MODE_TARGET, 13'd2000);
        send_item(MODE_TICK, 13'h0AAA);
        send_item(MODE_ENABLE, ENABLE_ON);
    endtask

    task automatic test_fast_ramp_steps();
        reconfigure(16'hFFFF, 16'h0000);
        send_item(MODE_TARGET, 13'd4095);
        send_item(MODE_ENABLE, ENABLE_ON);
        repeat (8) send_item(MODE_TICK, 13'h0000);
        send_item(MODE_TARGET, 13'h1FFB);
        repeat (2) send_item(MODE_TICK, 13'h1FFF);
        send_item(MODE_ENABLE, ENABLE_OFF);
        send_item(MODE_TICK, 13'h0000);
    endtask

    task automatic test_spare_registers();
        wait_idle();
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        repeat (10) send_random_item(80);
    endtask

    task automatic test_unit_rpm_step();
        reconfigure(16'h0001, 16'h0000);
        send_item(MODE_ENABLE, ENABLE_ON);
        repeat (200) send_random_item(85);
    endtask

    task automatic test_random_rpm_step();
        reconfigure(CFG_DATA_W'($urandom), 16'h0000);
        send_item(MODE_ENABLE, ENABLE_ON);
        repeat (250) send_random_item(85);
    endtask

    task automatic test_frozen_speed();
        reconfigure(16'h0000, 16'h0000);
        repeat (100) send_random_item(80);
    endtask

    task automatic test_millisecond_ramp();
        reconfigure(16'hAFFF, 16'h0001);
        send_item(MODE_ENABLE, ENABLE_ON);
        send_item(MODE_TARGET, 13'd4095);
        repeat (1050) send_random_item(98);
    endtask

    task automatic test_slowest_ramp();
        reconfigure(16'h0FFF, 16'hFFFF);
        repeat (50) send_random_item(85);
    endtask

    task automatic test_result_backpressure();
        reconfigure(16'h0200, 16'h0000);
        send_item(MODE_ENABLE, ENABLE_ON);
        hold_off_requests = hold_off_requests + 1;
        repeat (150) send_random_item(85);
    endtask

    // receiver pacing: rotate among ready styles; hold off on request
    always @(negedge clk)
    begin : result_pacing
        int unsigned ready_style;
        int unsigned ready_phase_left;
        int unsigned hold_off_left;
        int unsigned hold_off_seen;
        if (hold_off_seen != hold_off_requests)
        begin
            hold_off_seen = hold_off_requests;
            hold_off_left = HOLD_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left = hold_off_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (ready_phase_left == 0)
            begin
                ready_style      = $urandom_range(0, 2);
                ready_phase_left = $urandom_range(16, 96);
            end
            else
                ready_phase_left = ready_phase_left - 1;
            case (ready_style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        motor_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_motor_outs.size() == 0)
            begin
                $display("%0t: unexpected result transfer speed=%0d", $time, current_speed);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = pending_motor_outs.pop_front();
                if (step_pulse !== want.step_pulse)
                begin
                    $display("%0t: step_pulse expected %0b actual %0b",
                             $time, want.step_pulse, step_pulse);
                    mismatches = mismatches + 1;
                end
                if (current_speed !== want.current_speed)
                begin
                    $display("%0t: current_speed expected %0d actual %0d",
                             $time, want.current_speed, current_speed);
                    mismatches = mismatches + 1;
                end
                if (direction !== want.direction)
                begin
                    $display("%0t: direction expected %0b actual %0b",
                             $time, want.direction, direction);
                    mismatches = mismatches + 1;
                end
                if (driver_enabled !== want.driver_enabled)
                begin
                    $display("%0t: driver_enabled expected %0b actual %0b",
                             $time, want.driver_enabled, driver_enabled);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        test_command_decode();
        test_fast_ramp_steps();
        test_spare_registers();
        test_unit_rpm_step();
        test_random_rpm_step();
        test_frozen_speed();
        test_millisecond_ramp();
        test_slowest_ramp();
        test_result_backpressure();
        wait_idle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/srsg_pkg.sv
hdl/srsg_ctrl.sv
hdl/srsg_datapath.sv
hdl/stepper_ramp_step_generator_core.sv
verif/tb_top.sv
